[rtl/assert_macros.svh]
// Assertion macros for the RTL of the uplink message queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ucq_pkg.sv]
// Package with the shared constants and types of the uplink message queue.
package ucq_pkg;

  localparam int QUEUE_LIMIT_DEF = 32;
  localparam int MAX_PAYLOAD_DEF = 51;

  localparam int PORT_W = 8;
  localparam int BYTE_W = 8;
  localparam int QC_W   = 6;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_BUILD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEN,
    ST_BYTES,
    ST_EMPTY
  } state_t;

endpackage

[rtl/ucq_if.sv]
// Handshake interfaces for the request channel and the packet channel.
interface ucq_cmd_if;
  import ucq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [PORT_W-1:0] msg_port;
  logic [BYTE_W-1:0] msg_byte;
  logic              msg_last;

  modport source (output valid, output req_type, output msg_port, output msg_byte,
                  output msg_last, input ready);
  modport sink (input valid, input req_type, input msg_port, input msg_byte,
                input msg_last, output ready);
endinterface

interface ucq_pkt_if;
  import ucq_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] pkt_port;
  logic [BYTE_W-1:0] pkt_byte;
  logic              pkt_last;
  logic              pkt_empty;
  logic [QC_W-1:0]   queued_count;

  modport source (output valid, output pkt_port, output pkt_byte, output pkt_last,
                  output pkt_empty, output queued_count, input ready);
  modport sink (input valid, input pkt_port, input pkt_byte, input pkt_last,
                input pkt_empty, input queued_count, output ready);
endinterface

[rtl/ucq_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module ucq_ram #(
  parameter int WIDTH = ucq_pkg::BYTE_W,
  parameter int DEPTH = ucq_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/uplink_message_coalescing_queue.sv]
// Pushes keep the queue idle and can come back to back. A build first scans message
// headers from the header memory at one message per cycle, then streams payload
// bytes from the payload memory at one byte per cycle while the packet channel
// does not stall, passing ST_LEN per popped message to read its length. A build
// on an empty queue gives its single result via ST_EMPTY and the rd and out
// registers; one that pops only empty messages scans their headers first. Requests
// are not taken while a build is in progress, but a new build or push may start
// while earlier results still drain. No clearing pass is needed after reset.
module uplink_message_coalescing_queue #(
  parameter int QUEUE_LIMIT = ucq_pkg::QUEUE_LIMIT_DEF,
  parameter int MAX_PAYLOAD = ucq_pkg::MAX_PAYLOAD_DEF
) (
  input logic      clk,
  input logic      rst,
  ucq_cmd_if.sink  cmd,
  ucq_pkt_if.source pkt
);
  import ucq_pkg::*;

  localparam int SLOT_COUNT  = QUEUE_LIMIT + 1;
  localparam int STORE_DEPTH = SLOT_COUNT * MAX_PAYLOAD;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int META_W      = PORT_W + LEN_W;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] base_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [ADDR_W-1:0] b);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : b + ADDR_W'(MAX_PAYLOAD);
  endfunction

  state_t state, state_next;

  logic [SLOT_W-1:0] head_slot, tail_slot, scan_slot, st_slot;
  logic [ADDR_W-1:0] head_base, tail_base, scan_base, st_base;
  logic [CNT_W-1:0]  count, pops;
  logic [LEN_W-1:0]  fill, total, cur_len, byte_idx, sent;
  logic              overlong, first;
  logic [PORT_W-1:0] pkt_port_r;

  logic              rd_valid, rd_last, rd_empty;
  logic [PORT_W-1:0] rd_port;
  logic [QC_W-1:0]   rd_qc;

  logic              out_valid, out_last, out_empty;
  logic [PORT_W-1:0] out_port;
  logic [BYTE_W-1:0] out_byte;
  logic [QC_W-1:0]   out_qc;

  logic              cmd_ready, push, build, drop;
  logic              move, can_issue;
  logic              fill_room, overlong_new;
  logic [LEN_W-1:0]  fill_new, len_commit;
  logic [CNT_W-1:0]  count_push;

  logic              meta_wr_en, meta_rd_en;
  logic [SLOT_W-1:0] meta_rd_addr;
  logic [META_W-1:0] meta_wdata, meta_q;
  logic              pay_wr_en, pay_rd_en;
  logic [ADDR_W-1:0] pay_wr_addr, pay_rd_addr;
  logic [BYTE_W-1:0] pay_q;

  logic [PORT_W-1:0] rport;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W:0]    sum;
  logic              take, more;
  logic [CNT_W-1:0]  pops_inc, pops_fin;
  logic [LEN_W-1:0]  total_fin;
  logic [SLOT_W-1:0] scan_next_slot, st_next_slot;
  logic [ADDR_W-1:0] scan_next_base, st_next_base;
  logic [LEN_W-1:0]  sent_inc, byte_inc;
  logic              byte_pkt_last, slot_end;
  logic              bytes_issue, empty_issue;

  // Handshake and push datapath.
  assign cmd_ready = (state == ST_IDLE);
  assign push      = cmd.valid && cmd_ready && (cmd.req_type == REQ_PUSH);
  assign build     = cmd.valid && cmd_ready && (cmd.req_type == REQ_BUILD);
  assign cmd.ready = cmd_ready;

  assign move      = rd_valid && (!out_valid || pkt.ready);
  assign can_issue = !rd_valid || move;

  assign drop         = (fill == '0) && (count > CNT_W'(QUEUE_LIMIT));
  assign fill_room    = (fill < LEN_W'(MAX_PAYLOAD));
  assign fill_new     = fill_room ? fill + 1'b1 : fill;
  assign overlong_new = overlong || !fill_room;
  assign len_commit   = overlong_new ? '0 : fill_new;
  assign count_push   = count - CNT_W'(drop) + CNT_W'(cmd.msg_last);

  assign pay_wr_en   = push && fill_room;
  assign pay_wr_addr = tail_base + ADDR_W'(fill);
  assign meta_wr_en  = push && cmd.msg_last;
  assign meta_wdata  = {cmd.msg_port, len_commit};

  // Header scan and byte streaming.
  assign rport    = meta_q[META_W-1 -: PORT_W];
  assign rlen     = meta_q[LEN_W-1:0];
  assign sum      = {1'b0, total} + {1'b0, rlen};
  assign take     = first || ((rport == pkt_port_r) && (sum <= (LEN_W+1)'(MAX_PAYLOAD)));
  assign pops_inc = pops + 1'b1;
  assign more     = take && (pops_inc < count);
  assign pops_fin  = take ? pops_inc : pops;
  assign total_fin = take ? sum[LEN_W-1:0] : total;

  assign scan_next_slot = slot_inc(scan_slot);
  assign scan_next_base = base_inc(scan_slot, scan_base);
  assign st_next_slot   = slot_inc(st_slot);
  assign st_next_base   = base_inc(st_slot, st_base);

  assign sent_inc      = sent + 1'b1;
  assign byte_inc      = byte_idx + 1'b1;
  assign byte_pkt_last = (sent_inc == total);
  assign slot_end      = (byte_inc == cur_len);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (build) begin
          state_next = (count == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!more) begin
          state_next = (total_fin == '0) ? ST_EMPTY : ST_LEN;
        end
      end
      ST_LEN: begin
        if (rlen != '0) begin
          state_next = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (can_issue) begin
          if (byte_pkt_last) begin
            state_next = ST_IDLE;
          end else if (slot_end) begin
            state_next = ST_LEN;
          end
        end
      end
      ST_EMPTY: begin
        if (can_issue) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    meta_rd_en   = 1'b0;
    meta_rd_addr = head_slot;
    bytes_issue  = 1'b0;
    empty_issue  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        meta_rd_en = build;
      end
      ST_SCAN: begin
        if (more) begin
          meta_rd_en   = 1'b1;
          meta_rd_addr = scan_next_slot;
        end else begin
          meta_rd_en = (total_fin != '0);
        end
      end
      ST_LEN: begin
        meta_rd_en   = (rlen == '0);
        meta_rd_addr = st_next_slot;
      end
      ST_BYTES: begin
        bytes_issue  = can_issue;
        meta_rd_en   = can_issue && slot_end && !byte_pkt_last;
        meta_rd_addr = st_next_slot;
      end
      ST_EMPTY: begin
        empty_issue = can_issue;
      end
      default: begin
        meta_rd_en = 1'b0;
      end
    endcase
  end

  assign pay_rd_en   = bytes_issue;
  assign pay_rd_addr = st_base + ADDR_W'(byte_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_slot <= '0;
      head_base <= '0;
      tail_slot <= '0;
      tail_base <= '0;
      count     <= '0;
      fill      <= '0;
      overlong  <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (push) begin
        if (drop) begin
          head_slot <= slot_inc(head_slot);
          head_base <= base_inc(head_slot, head_base);
        end
        count <= count_push;
        if (cmd.msg_last) begin
          tail_slot <= slot_inc(tail_slot);
          tail_base <= base_inc(tail_slot, tail_base);
          fill      <= '0;
          overlong  <= 1'b0;
        end else begin
          fill     <= fill_new;
          overlong <= overlong_new;
        end
      end

      if (state == ST_SCAN && !more) begin
        head_slot <= take ? scan_next_slot : scan_slot;
        head_base <= take ? scan_next_base : scan_base;
        count     <= count - pops_fin;
      end

      if (bytes_issue || empty_issue) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
      end else if (pkt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build) begin
      scan_slot <= head_slot;
      scan_base <= head_base;
      pops      <= '0;
      total     <= '0;
      first     <= 1'b1;
      if (count == '0) begin
        pkt_port_r <= '0;
      end
    end

    if (state == ST_SCAN) begin
      if (take) begin
        scan_slot <= scan_next_slot;
        scan_base <= scan_next_base;
        pops      <= pops_inc;
        total     <= sum[LEN_W-1:0];
        first     <= 1'b0;
        if (first) begin
          pkt_port_r <= rport;
        end
      end
      if (!more) begin
        st_slot <= head_slot;
        st_base <= head_base;
        sent    <= '0;
      end
    end

    if (state == ST_LEN) begin
      if (rlen == '0) begin
        st_slot <= st_next_slot;
        st_base <= st_next_base;
      end else begin
        cur_len  <= rlen;
        byte_idx <= '0;
      end
    end

    if (bytes_issue) begin
      sent     <= sent_inc;
      byte_idx <= byte_inc;
      if (slot_end) begin
        st_slot <= st_next_slot;
        st_base <= st_next_base;
      end
    end

    if (bytes_issue || empty_issue) begin
      rd_port  <= pkt_port_r;
      rd_last  <= empty_issue || byte_pkt_last;
      rd_empty <= empty_issue;
      rd_qc    <= QC_W'(count);
    end

    if (move) begin
      out_port  <= rd_port;
      out_byte  <= rd_empty ? '0 : pay_q;
      out_last  <= rd_last;
      out_empty <= rd_empty;
      out_qc    <= rd_qc;
    end
  end

  assign pkt.valid        = out_valid;
  assign pkt.pkt_port     = out_port;
  assign pkt.pkt_byte     = out_byte;
  assign pkt.pkt_last     = out_last;
  assign pkt.pkt_empty    = out_empty;
  assign pkt.queued_count = out_qc;

  ucq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_payload (
    .clk     (clk),
    .wr_en   (pay_wr_en),
    .wr_addr (pay_wr_addr),
    .wr_data (cmd.msg_byte),
    .rd_en   (pay_rd_en),
    .rd_addr (pay_rd_addr),
    .rd_data (pay_q)
  );

  ucq_ram #(
    .WIDTH (META_W),
    .DEPTH (SLOT_COUNT)
  ) u_header (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (tail_slot),
    .wr_data (meta_wdata),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_q)
  );

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(SLOT_COUNT), "Message count overflow.")
  `ASSERT_IMPLIES(a_ring_even, clk, rst, (count == '0) || (count == CNT_W'(SLOT_COUNT)), head_slot == tail_slot, "Head and tail disagree with the count.")
  `ASSERT_IMPLIES(a_scan_bound, clk, rst, state == ST_SCAN, pops < count, "Scan ran past the held messages.")
  `ASSERT_NEXT(a_empty_build, clk, rst, build && (count == '0), state == ST_EMPTY, "Build on an empty queue must give an empty packet.")
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the uplink message coalescing queue: push and build requests with a packet predictor.
module tb_top;
  import ucq_pkg::*;

  localparam int SLOTS = QUEUE_LIMIT_DEF + 1;
  localparam int MAXP = MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 150;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              empty;
    logic [QC_W-1:0]   count;
  } pkt_beat_t;

  logic clk;
  logic rst;

  ucq_cmd_if cmd();
  ucq_pkt_if pkt();

  uplink_message_coalescing_queue u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .pkt(pkt)
  );

  logic [BYTE_W-1:0] held_bytes [SLOTS*MAXP];
  logic [PORT_W-1:0] held_port [SLOTS];
  int unsigned held_len [SLOTS];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  int unsigned held_count = 0;
  int unsigned fill_pos = 0;
  bit overlong = 1'b0;

  pkt_beat_t pending_beats[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned req_count = 0;
  int unsigned build_count = 0;
  int unsigned beat_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [PORT_W-1:0] port_pool [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    pkt.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void drop_oldest();
    head_idx = (head_idx + 1 == SLOTS) ? 0 : head_idx + 1;
    held_count--;
  endfunction

  function automatic void queue_push_model(input logic [PORT_W-1:0] port,
                                           input logic [BYTE_W-1:0] data,
                                           input logic last);
    if (fill_pos == 0 && held_count > QUEUE_LIMIT_DEF) drop_oldest();
    if (fill_pos < MAXP) begin
      held_bytes[tail_idx*MAXP + fill_pos] = data;
      fill_pos++;
    end else begin
      overlong = 1'b1;
    end
    held_port[tail_idx] = port;
    if (last) begin
      held_len[tail_idx] = overlong ? 0 : fill_pos;
      tail_idx = (tail_idx + 1 == SLOTS) ? 0 : tail_idx + 1;
      held_count++;
      fill_pos = 0;
      overlong = 1'b0;
    end
  endfunction

  function automatic void queue_build_model();
    pkt_beat_t packet[$];
    pkt_beat_t beat;
    logic [PORT_W-1:0] port;
    int unsigned packed_bytes;
    if (held_count == 0) begin
      beat = '{port: '0, data: '0, last: 1'b1, empty: 1'b1, count: '0};
      packet.push_back(beat);
    end else begin
      port = held_port[head_idx];
      packed_bytes = 0;
      while (held_count > 0 && held_port[head_idx] == port &&
             packed_bytes + held_len[head_idx] <= MAXP) begin
        for (int unsigned i = 0; i < held_len[head_idx]; i++) begin
          beat = '{port: port, data: held_bytes[head_idx*MAXP + i], last: 1'b0,
                   empty: 1'b0, count: '0};
          packet.push_back(beat);
          packed_bytes++;
        end
        drop_oldest();
      end
      if (packed_bytes == 0) begin
        beat = '{port: port, data: '0, last: 1'b1, empty: 1'b1, count: '0};
        packet.push_back(beat);
      end else begin
        packet[packet.size()-1].last = 1'b1;
      end
    end
    foreach (packet[i]) begin
      packet[i].count = held_count[QC_W-1:0];
      pending_beats.push_back(packet[i]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : beat_checker
    pkt_beat_t want;
    if (!rst && pkt.valid === 1'b1 && pkt.ready === 1'b1) begin
      beat_count++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat port %0h byte %0h last %0b empty %0b",
                                  pkt.pkt_port, pkt.pkt_byte, pkt.pkt_last, pkt.pkt_empty));
      end else begin
        want = pending_beats.pop_front();
        check_field("pkt_port", pkt.pkt_port, want.port);
        check_field("pkt_byte", pkt.pkt_byte, want.data);
        check_field("pkt_last", {7'd0, pkt.pkt_last}, {7'd0, want.last});
        check_field("pkt_empty", {7'd0, pkt.pkt_empty}, {7'd0, want.empty});
        check_field("queued_count", {2'd0, pkt.queued_count}, {2'd0, want.count});
      end
    end
  end

  task automatic send_req(input logic kind, input logic [PORT_W-1:0] port,
                          input logic [BYTE_W-1:0] data, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.req_type <= kind;
    cmd.msg_port <= port;
    cmd.msg_byte <= data;
    cmd.msg_last <= last;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    req_count++;
    if (kind == REQ_PUSH) begin
      queue_push_model(port, data, last);
    end else begin
      build_count++;
      queue_build_model();
    end
  endtask

  task automatic send_build();
    send_req(REQ_BUILD, PORT_W'($urandom), BYTE_W'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic push_message(input logic [PORT_W-1:0] port, input int len,
                              input int unsigned mid_build_pct);
    logic last;
    logic [PORT_W-1:0] byte_port;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < mid_build_pct) send_build();
      last = (i == len - 1);
      byte_port = (last || $urandom_range(3) != 0) ? port : PORT_W'($urandom);
      send_req(REQ_PUSH, byte_port, BYTE_W'($urandom), last);
    end
  endtask

  task automatic test_basic_packets();
    send_req(REQ_BUILD, 8'hFF, 8'hFF, 1'b1);
    send_req(REQ_PUSH, 8'hFF, 8'h00, 1'b0);
    send_req(REQ_PUSH, 8'h00, 8'hFF, 1'b1);
    send_req(REQ_PUSH, 8'h00, 8'hA5, 1'b1);
    send_req(REQ_PUSH, 8'hFF, 8'h5A, 1'b1);
    send_req(REQ_BUILD, 8'h00, 8'h00, 1'b0);
    send_req(REQ_BUILD, 8'h00, 8'h00, 1'b0);
    send_req(REQ_BUILD, 8'hFF, 8'h00, 1'b1);
    send_req(REQ_PUSH, 8'h3C, 8'h11, 1'b0);
    send_req(REQ_BUILD, 8'h3C, 8'hFF, 1'b0);
    send_req(REQ_PUSH, 8'hC3, 8'h22, 1'b1);
    send_req(REQ_BUILD, 8'hC3, 8'h00, 1'b1);
    wait_drained();
  endtask

  // A packet of exactly the payload limit, a message refused for length, a port
  // split, an overlong message alone and a build on the emptied queue.
  task automatic test_payload_limits();
    logic [PORT_W-1:0] port_a;
    logic [PORT_W-1:0] port_b;
    port_a = PORT_W'($urandom);
    port_b = port_a ^ 8'h5A;
    push_message(port_a, MAXP - 1, 0);
    push_message(port_a, 1, 0);
    push_message(port_a, 1, 0);
    push_message(port_b, MAXP + 1, 0);
    send_build();
    send_build();
    send_build();
    send_build();
    wait_drained();
  endtask

  task automatic test_queue_overflow();
    port_pool[0] = PORT_W'($urandom);
    port_pool[1] = PORT_W'($urandom);
    for (int i = 0; i < QUEUE_LIMIT_DEF + 3; i++) begin
      push_message(port_pool[(i / 12) % 2], 1, 0);
    end
    while (held_count != 0) send_build();
    send_build();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned sel;
    int unsigned len;
    logic [PORT_W-1:0] port;
    start = req_count;
    foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom);
    while (req_count - start < n_items) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        send_build();
      end else if (sel < 23) begin
        wait_drained();
      end else if (sel < 27) begin
        send_req(REQ_PUSH, PORT_W'($urandom), BYTE_W'($urandom), 1'($urandom_range(1)));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) len = $urandom_range(1, 6);
        else if (sel < 90) len = $urandom_range(7, 20);
        else if (sel < 95) len = $urandom_range(MAXP - 6, MAXP);
        else len = $urandom_range(MAXP + 1, MAXP + 3);
        port = ($urandom_range(4) != 0) ? port_pool[$urandom_range(2)] : PORT_W'($urandom);
        push_message(port, len, 8);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid <= 1'b0;
    cmd.req_type <= REQ_PUSH;
    cmd.msg_port <= '0;
    cmd.msg_byte <= '0;
    cmd.msg_last <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 80;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_payload_limits();

    send_idle_pct = 80;
    recv_idle_pct = 28;
    test_queue_overflow();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_basic_packets();
    test_random_traffic(12);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests including %0d packet builds, and checked %0d packet beats.",
             req_count, build_count, beat_count);
    $display("Covered empty builds, port splits, payload limits, overlong and dropped messages.");
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
